@@ rtl/grs_pkg.sv @@
// Shared types, constants and codes of the glyph rasterizer.
package grs_pkg;

   localparam int DISPLAY_WIDTH_DEFAULT  = 128;
   localparam int DISPLAY_HEIGHT_DEFAULT = 64;
   localparam int CSR_ADDR_WIDTH         = 4;
   localparam int CSR_DATA_WIDTH         = 32;

   typedef enum logic [1:0] {
      REG_SCALE          = 2'd0,
      REG_QUARTER_TURNS  = 2'd1,
      REG_INVERT_GLYPH   = 2'd2,
      REG_RESTORE_AT_END = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      TURN_0   = 2'd0,
      TURN_90  = 2'd1,
      TURN_180 = 2'd2,
      TURN_270 = 2'd3
   } turn_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_EMIT    = 2'd1,
      ST_ADVANCE = 2'd2
   } state_type;

   typedef enum logic {
      CMD_SET_CURSOR = 1'b0,
      CMD_DRAW_GLYPH = 1'b1
   } req_cmd_type;

   typedef struct packed {
      logic        cmd;
      logic [5:0]  new_row;
      logic [6:0]  new_col;
      logic [63:0] glyph_bits;
      logic        end_of_text;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] page_index;
      logic [6:0] column_index;
      logic [7:0] pixel_byte;
      logic       last_write;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0] scale;
      logic [1:0] quarter_turns;
      logic       invert_glyph;
      logic       restore_at_end;
   } cfg_type;

   typedef struct packed {
      logic take_set;
      logic take_glyph;
      logic emit;
      logic advance;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_glyph;
      logic clipped;
      logic last_item;
      logic out_free;
   } ctrl_status_type;

endpackage

@@ rtl/glyph_rasterizer_rotate_scale_top.sv @@
// Top level of the 8x8 glyph rasterizer with scaling and rotation.
//
// Request channel (req_valid/req_ready/req_data): a set-cursor command or
// one 8x8 glyph to draw at the kept cursor. Response channel
// (rsp_valid/rsp_ready/rsp_data): one whole-byte framebuffer write per
// transfer, last_write marking the final write of a glyph.
// Registers (scale, quarter_turns, invert_glyph, restore_at_end) sit at
// byte offsets 0, 4, 8, 12 of the APB-style port; pready is always high.
// Sequence: a set-cursor command is taken in the idle state. A glyph is
// accepted, then emits one write per column byte (8 or 16 columns times 1
// to 3 pages, fewer when clipped at the right edge, at most 48), then
// advances the cursor. The first write reaches rsp_valid through the state
// register and then the output register after the request transfer. The
// emission sequencer produces one byte per cycle while the output is free.
// A stalled receiver holds the output register; emission pauses until it
// frees. The next request is taken while the final write still waits.
// Reset clears the cursor, the open-text flag and the output valid flag, and
// loads scale=1, quarter_turns=0, invert_glyph=0, restore_at_end=1.
module glyph_rasterizer_rotate_scale_top #(
   parameter int DISPLAY_WIDTH  = grs_pkg::DISPLAY_WIDTH_DEFAULT,
   parameter int DISPLAY_HEIGHT = grs_pkg::DISPLAY_HEIGHT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  grs_pkg::req_payload_type           req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output grs_pkg::rsp_payload_type           rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [grs_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [grs_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [grs_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                               pready
);

   grs_pkg::cfg_type         cfg;
   grs_pkg::ctrl_cmd_type    ctrl_cmd;
   grs_pkg::ctrl_status_type ctrl_status;

   grs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   grs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (ctrl_status),
      .cmd       (ctrl_cmd)
   );

   grs_datapath #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .cmd       (ctrl_cmd),
      .status    (ctrl_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/grs_csr.sv @@
// Configuration register file with APB-style access.
module grs_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [grs_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [grs_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [grs_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                 pready,
   output grs_pkg::cfg_type                     cfg
);

   grs_pkg::cfg_type      cfg_ff;
   grs_pkg::cfg_type      cfg_in;
   grs_pkg::reg_index_type reg_index;
   logic                  wr_en;

   assign reg_index = grs_pkg::reg_index_type'(paddr[3:2]);
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            grs_pkg::REG_SCALE:          cfg_in.scale          = pwdata[1:0];
            grs_pkg::REG_QUARTER_TURNS:  cfg_in.quarter_turns  = pwdata[1:0];
            grs_pkg::REG_INVERT_GLYPH:   cfg_in.invert_glyph   = pwdata[0];
            grs_pkg::REG_RESTORE_AT_END: cfg_in.restore_at_end = pwdata[0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_index)
         grs_pkg::REG_SCALE:          prdata[1:0] = cfg_ff.scale;
         grs_pkg::REG_QUARTER_TURNS:  prdata[1:0] = cfg_ff.quarter_turns;
         grs_pkg::REG_INVERT_GLYPH:   prdata[0]   = cfg_ff.invert_glyph;
         grs_pkg::REG_RESTORE_AT_END: prdata[0]   = cfg_ff.restore_at_end;
         default:                     prdata      = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale          <= 2'd1;
         cfg_ff.quarter_turns  <= 2'd0;
         cfg_ff.invert_glyph   <= 1'b0;
         cfg_ff.restore_at_end <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/grs_ctrl.sv @@
// Sequencing state machine: accept, column-byte emission, cursor advance.
module grs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  grs_pkg::ctrl_status_type status,
   output grs_pkg::ctrl_cmd_type    cmd
);

   grs_pkg::state_type state_ff;
   grs_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         grs_pkg::ST_IDLE: begin
            if (req_valid && status.is_glyph) begin
               state_in = status.clipped ? grs_pkg::ST_ADVANCE : grs_pkg::ST_EMIT;
            end
         end
         grs_pkg::ST_EMIT: begin
            if (status.out_free && status.last_item) begin
               state_in = grs_pkg::ST_ADVANCE;
            end
         end
         grs_pkg::ST_ADVANCE: state_in = grs_pkg::ST_IDLE;
         default:             state_in = grs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         grs_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.take_set   = req_valid && !status.is_glyph;
            cmd.take_glyph = req_valid && status.is_glyph;
         end
         grs_pkg::ST_EMIT:    cmd.emit    = status.out_free;
         grs_pkg::ST_ADVANCE: cmd.advance = 1'b1;
         default:             cmd         = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= grs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/grs_datapath.sv @@
// Cursor state, glyph sampling, column-byte builder and output register.
module grs_datapath #(
   parameter int DISPLAY_WIDTH  = grs_pkg::DISPLAY_WIDTH_DEFAULT,
   parameter int DISPLAY_HEIGHT = grs_pkg::DISPLAY_HEIGHT_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  grs_pkg::req_payload_type req_data,
   input  grs_pkg::cfg_type         cfg,
   input  grs_pkg::ctrl_cmd_type    cmd,
   output grs_pkg::ctrl_status_type status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output grs_pkg::rsp_payload_type rsp_data
);

   localparam logic [7:0] WIDTH_LIMIT  = 8'(DISPLAY_WIDTH);
   localparam logic [7:0] HEIGHT_LIMIT = 8'(DISPLAY_HEIGHT);

   logic [5:0]  cur_row_ff, cur_row_in;
   logic [6:0]  cur_col_ff, cur_col_in;
   logic [5:0]  start_row_ff, start_row_in;
   logic [6:0]  start_col_ff, start_col_in;
   logic        text_open_ff, text_open_in;
   logic [63:0] glyph_ff, glyph_in;
   logic        eot_ff, eot_in;
   logic [1:0]  page_ofs_ff, page_ofs_in;
   logic [3:0]  col_ofs_ff, col_ofs_in;
   logic        rsp_valid_ff, rsp_valid_in;
   grs_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic       wide;
   logic [3:0] s_m1;
   logic [7:0] size8;
   logic [6:0] end_row;
   logic [2:0] page;
   logic [7:0] col_abs;
   logic       col_last;
   logic       last_page;
   logic       last_item;
   logic [7:0] pixel_byte;
   logic [5:0] adv_row;
   logic [6:0] adv_col;

   assign wide      = cfg.scale[1];
   assign s_m1      = wide ? 4'd15 : 4'd7;
   assign size8     = wide ? 8'd16 : 8'd8;
   assign end_row   = {1'b0, cur_row_ff} + {3'b000, s_m1};
   assign page      = cur_row_ff[5:3] + {1'b0, page_ofs_ff};
   assign last_page = ({1'b0, cur_row_ff[5:3]} + {2'b00, page_ofs_ff}) == end_row[6:3];
   assign col_abs   = {1'b0, cur_col_ff} + {4'b0000, col_ofs_ff};
   assign col_last  = (col_ofs_ff == s_m1) || ((col_abs + 8'd1) >= WIDTH_LIMIT);
   assign last_item = col_last && last_page;

   assign status.is_glyph  = req_data.cmd == grs_pkg::CMD_DRAW_GLYPH;
   assign status.clipped   = {1'b0, cur_col_ff} >= WIDTH_LIMIT;
   assign status.last_item = last_item;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // one column byte: eight glyph samples in parallel
   always_comb begin
      logic [5:0] row;
      logic [5:0] dy;
      logic [3:0] x;
      logic [3:0] y;
      logic [3:0] rx;
      logic [3:0] ry;
      logic [2:0] rx3;
      logic [2:0] ry3;
      pixel_byte = '0;
      for (int b = 0; b < 8; b++) begin
         row = {page, 3'(b)};
         dy  = row - cur_row_ff;
         x   = col_ofs_ff;
         y   = dy[3:0];
         case (grs_pkg::turn_type'(cfg.quarter_turns))
            grs_pkg::TURN_0:   begin rx = x;        ry = y;        end
            grs_pkg::TURN_90:  begin rx = y;        ry = s_m1 - x; end
            grs_pkg::TURN_180: begin rx = s_m1 - x; ry = s_m1 - y; end
            grs_pkg::TURN_270: begin rx = s_m1 - y; ry = x;        end
            default:           begin rx = x;        ry = y;        end
         endcase
         rx3 = wide ? rx[3:1] : rx[2:0];
         ry3 = wide ? ry[3:1] : ry[2:0];
         if ((row >= cur_row_ff) && (dy <= {2'b00, s_m1})) begin
            pixel_byte[b] = glyph_ff[{ry3, rx3}];
         end
      end
   end

   // cursor advance by rotation
   always_comb begin
      logic [7:0] r;
      logic [7:0] c;
      r = {2'b00, cur_row_ff};
      c = {1'b0, cur_col_ff};
      case (grs_pkg::turn_type'(cfg.quarter_turns))
         grs_pkg::TURN_0: begin
            if (c + size8 < WIDTH_LIMIT) begin
               c = c + size8;
            end else begin
               c = 8'd0;
               r = (r < HEIGHT_LIMIT - size8) ? r + size8 : 8'd0;
            end
         end
         grs_pkg::TURN_90: begin
            if (r + size8 < HEIGHT_LIMIT) begin
               r = r + size8;
            end else begin
               r = 8'd0;
               c = (c >= size8) ? c - size8 : WIDTH_LIMIT - size8;
            end
         end
         grs_pkg::TURN_180: begin
            if (c >= size8) begin
               c = c - size8;
            end else begin
               c = WIDTH_LIMIT - size8;
               r = (r >= size8) ? r - size8 : HEIGHT_LIMIT - size8;
            end
         end
         grs_pkg::TURN_270: begin
            if (r >= size8) begin
               r = r - size8;
            end else begin
               r = HEIGHT_LIMIT - size8;
               c = (c < WIDTH_LIMIT - size8) ? c + size8 : 8'd0;
            end
         end
         default: begin
            r = {2'b00, cur_row_ff};
            c = {1'b0, cur_col_ff};
         end
      endcase
      adv_row = r[5:0];
      adv_col = c[6:0];
   end

   always_comb begin
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      start_row_in = start_row_ff;
      start_col_in = start_col_ff;
      text_open_in = text_open_ff;
      glyph_in     = glyph_ff;
      eot_in       = eot_ff;
      page_ofs_in  = page_ofs_ff;
      col_ofs_in   = col_ofs_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.take_set) begin
         cur_row_in   = req_data.new_row;
         cur_col_in   = req_data.new_col;
         text_open_in = 1'b0;
      end

      if (cmd.take_glyph) begin
         glyph_in    = cfg.invert_glyph ? ~req_data.glyph_bits : req_data.glyph_bits;
         eot_in      = req_data.end_of_text;
         page_ofs_in = '0;
         col_ofs_in  = '0;
         if (!text_open_ff) begin
            start_row_in = cur_row_ff;
            start_col_in = cur_col_ff;
            text_open_in = 1'b1;
         end
      end

      if (cmd.emit) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.page_index   = page;
         rsp_data_in.column_index = col_abs[6:0];
         rsp_data_in.pixel_byte   = pixel_byte;
         rsp_data_in.last_write   = last_item;
         if (col_last) begin
            col_ofs_in  = '0;
            page_ofs_in = page_ofs_ff + 2'd1;
         end else begin
            col_ofs_in = col_ofs_ff + 4'd1;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.advance) begin
         cur_row_in = adv_row;
         cur_col_in = adv_col;
         if (eot_ff) begin
            text_open_in = 1'b0;
            if (cfg.restore_at_end) begin
               cur_row_in = start_row_ff;
               cur_col_in = start_col_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         start_row_ff <= '0;
         start_col_ff <= '0;
         text_open_ff <= 1'b0;
         page_ofs_ff  <= '0;
         col_ofs_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         start_row_ff <= start_row_in;
         start_col_ff <= start_col_in;
         text_open_ff <= text_open_in;
         page_ofs_ff  <= page_ofs_in;
         col_ofs_ff   <= col_ofs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff    <= glyph_in;
      eot_ff      <= eot_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ rtl/grs_checker.sv @@
// Port-level checks of the glyph rasterizer and their bind to the top level.
module grs_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input grs_pkg::req_payload_type req_data,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input grs_pkg::rsp_payload_type rsp_data
);

   // no stale write survives reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // glyph transfer blocks the request side in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.cmd == grs_pkg::CMD_DRAW_GLYPH) |=> !req_ready)
      else $error("request taken during glyph drawing");

   // set-cursor keeps the request side open
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.cmd == grs_pkg::CMD_SET_CURSOR) |=> req_ready)
      else $error("set-cursor stalled the request side");

   // stalled write holds its value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind glyph_rasterizer_rotate_scale_top grs_checker u_grs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
